// File: sv/acts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acts_pkg;

    localparam int unsigned COUNT_BITS_DEF = 32;

    localparam logic [29:0] NS_PER_S  = 30'd1000000000;
    // largest whole-second count whose ns value stays below 2^63
    localparam logic [33:0] WHOLE_MAX = 34'd9223372036;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    localparam int unsigned CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EPOCH = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE  = 8'd1;

    localparam logic [62:0] EPOCH_RST = 63'd1;
    localparam logic [19:0] RATE_RST  = 20'd48000;

    typedef enum logic [3:0] {
        STS_OK         = 4'd0,
        STS_BAD_CHUNK  = 4'd1,
        STS_NO_TIME    = 4'd2,
        STS_TIME_NONPOS= 4'd3,
        STS_NEG_DELAY  = 4'd4,
        STS_DELAY_OVF  = 4'd5,
        STS_TIME_OVF   = 4'd6,
        STS_BEFORE_ANC = 4'd7,
        STS_INDEX_OVF  = 4'd8,
        STS_PRE_EPOCH  = 4'd9,
        STS_NONPOS_DUR = 4'd10,
        STS_OVERLAP    = 4'd11
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_EARLY,
        OP_OBS,
        OP_P1,
        OP_P1_END,
        OP_P2,
        OP_P2_END,
        OP_FINAL,
        OP_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic fail;
        logic conv_done;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// File: sv/acts_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface acts_chunk_if;
    logic        valid;
    logic        ready;
    logic        chunk_ok;
    logic [63:0] first_frame_index;
    logic [31:0] num_frames;
    logic signed [31:0] lag_frames;
    logic        status_time_valid;
    logic signed [63:0] status_time_ns;
    logic        discontinuity;

    modport source (output valid, chunk_ok, first_frame_index, num_frames, lag_frames,
                    status_time_valid, status_time_ns, discontinuity, input ready);
    modport sink (input valid, chunk_ok, first_frame_index, num_frames, lag_frames,
                  status_time_valid, status_time_ns, discontinuity, output ready);
endinterface

interface acts_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [62:0] pts_ns;
    logic [62:0] span_ns;
    logic signed [63:0] predicted_start_ns;
    logic signed [63:0] observed_start_ns;
    logic signed [63:0] start_error_ns;
    logic        reanchored;
    logic [31:0] failure_count;
    logic [31:0] reanchor_count;
    logic [31:0] discontinuity_count;
    logic [31:0] stamped_count;
    logic [62:0] max_abs_error_ns;

    modport source (output valid, status, pts_ns, span_ns, predicted_start_ns,
                    observed_start_ns, start_error_ns, reanchored, failure_count,
                    reanchor_count, discontinuity_count, stamped_count, max_abs_error_ns,
                    input ready);
    modport sink (input valid, status, pts_ns, span_ns, predicted_start_ns,
                  observed_start_ns, start_error_ns, reanchored, failure_count,
                  reanchor_count, discontinuity_count, stamped_count, max_abs_error_ns,
                  output ready);
endinterface

interface acts_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/audio_chunk_timestamp_stamper_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// audio chunk timestamp stamper
// i_chunk: one beat per captured chunk descriptor (valid/ready)
// o_result: one result beat per chunk, status plus times and running counters
// i_cfg: register writes, index 0 epoch, index 1 sample rate, always ready;
//   write only while no chunk is in flight
// each chunk runs up to three frame-to-ns conversions on one shared
//   converter; a conversion is a 64-step restoring divide, a split multiply,
//   a 50-step remainder divide and a sum
// chunks rejected by the early checks skip the conversions and go straight
//   to the result beat
// one chunk at a time: i_chunk.ready is high only while the sequencer is idle
// the result register frees the input side: a new chunk is taken while the
//   previous result beat still waits; if the receiver stalls, the next result
//   holds in the sequencer until the register drains
// reset: anchor cleared, counters zero, epoch 1, rate 48000, no result pending
module audio_chunk_timestamp_stamper_unit #(
    parameter int unsigned COUNT_BITS = acts_pkg::COUNT_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    acts_chunk_if.sink    i_chunk,
    acts_result_if.source o_result,
    acts_cfg_if.sink      i_cfg
);

    // command and status between sequencer and datapath
    acts_pkg::t_cmd w_cmd;
    acts_pkg::t_sts w_sts;

    acts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath holds config, anchor, counters, converter and result register
    acts_dpath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_chunk  (i_chunk),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

`default_nettype wire

// File: sv/acts_conv.sv
`timescale 1ns / 1ps
`default_nettype none

// frames to ns: restoring divide, split multiply, remainder divide
module acts_conv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_frames,
    input  wire logic [19:0] i_rate,
    output logic             o_done,
    output logic             o_ok,
    output logic [62:0]      o_ns
);

    typedef enum logic [2:0] {C_IDLE, C_DIV1, C_MUL_LO, C_MUL_HI, C_DIV2, C_SUM} t_cstate;

    t_cstate     r_state;
    logic [63:0] r_num;
    logic [19:0] r_rem;
    logic [5:0]  r_cnt;
    logic [33:0] r_whole;
    logic [63:0] r_acc;
    logic        r_done;
    logic        r_ok;
    logic [62:0] r_ns;

    logic [20:0] w_trial;
    logic        w_ge;
    logic [19:0] w_rem;
    logic [63:0] w_quot;
    logic [46:0] w_plo;
    logic [46:0] w_phi;
    logic [49:0] w_prem;
    logic [63:0] w_sum;

    always_comb begin
        w_trial = {r_rem, r_num[63]};
        w_ge    = w_trial >= {1'b0, i_rate};
        w_rem   = w_ge ? 20'(w_trial - {1'b0, i_rate}) : w_trial[19:0];
        w_quot  = {r_num[62:0], w_ge};
        w_plo   = 47'(r_whole[16:0]) * 47'(acts_pkg::NS_PER_S);
        w_phi   = 47'(r_whole[33:17]) * 47'(acts_pkg::NS_PER_S);
        w_prem  = 50'(r_rem) * 50'(acts_pkg::NS_PER_S);
        w_sum   = r_acc + {14'd0, r_num[49:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_rate == 20'd0) begin
                            r_done <= 1'b1;
                            r_ok   <= 1'b0;
                        end else begin
                            r_num   <= i_frames;
                            r_rem   <= 20'd0;
                            r_cnt   <= 6'd63;
                            r_state <= C_DIV1;
                        end
                    end
                end
                C_DIV1: begin
                    r_num <= w_quot;
                    r_rem <= w_rem;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        if (w_quot > {30'd0, acts_pkg::WHOLE_MAX}) begin
                            r_done  <= 1'b1;
                            r_ok    <= 1'b0;
                            r_state <= C_IDLE;
                        end else begin
                            r_whole <= w_quot[33:0];
                            r_state <= C_MUL_LO;
                        end
                    end
                end
                C_MUL_LO: begin
                    r_acc   <= {17'd0, w_plo};
                    r_num   <= {w_prem, 14'd0};
                    r_rem   <= 20'd0;
                    r_state <= C_MUL_HI;
                end
                C_MUL_HI: begin
                    r_acc   <= r_acc + {w_phi, 17'd0};
                    r_cnt   <= 6'd49;
                    r_state <= C_DIV2;
                end
                C_DIV2: begin
                    r_num <= w_quot;
                    r_rem <= w_rem;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= C_SUM;
                    end
                end
                C_SUM: begin
                    r_done  <= 1'b1;
                    r_ok    <= ~w_sum[63];
                    r_ns    <= w_sum[62:0];
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ok   = r_ok;
    assign o_ns   = r_ns;

endmodule

`default_nettype wire

// File: sv/acts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module acts_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire acts_pkg::t_sts i_sts,
    output acts_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_EARLY, S_OBS_WAIT, S_P1, S_P1_WAIT, S_P2, S_P2_WAIT, S_FINAL, S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = acts_pkg::OP_NONE;
        o_cmd.in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.op = acts_pkg::OP_CAPTURE;
                    n_state  = S_EARLY;
                end
            end
            S_EARLY: begin
                o_cmd.op = acts_pkg::OP_EARLY;
                n_state  = S_OBS_WAIT;
            end
            S_OBS_WAIT: begin
                if (i_sts.fail) begin
                    n_state = S_OUT;
                end else if (i_sts.conv_done) begin
                    o_cmd.op = acts_pkg::OP_OBS;
                    n_state  = S_P1;
                end
            end
            S_P1: begin
                if (i_sts.fail) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = acts_pkg::OP_P1;
                    n_state  = S_P1_WAIT;
                end
            end
            S_P1_WAIT: begin
                if (i_sts.fail) begin
                    n_state = S_OUT;
                end else if (i_sts.conv_done) begin
                    o_cmd.op = acts_pkg::OP_P1_END;
                    n_state  = S_P2;
                end
            end
            S_P2: begin
                if (i_sts.fail) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = acts_pkg::OP_P2;
                    n_state  = S_P2_WAIT;
                end
            end
            S_P2_WAIT: begin
                if (i_sts.fail) begin
                    n_state = S_OUT;
                end else if (i_sts.conv_done) begin
                    o_cmd.op = acts_pkg::OP_P2_END;
                    n_state  = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!i_sts.fail) begin
                    o_cmd.op = acts_pkg::OP_FINAL;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = acts_pkg::OP_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: sv/acts_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module acts_dpath #(
    parameter int unsigned COUNT_BITS = acts_pkg::COUNT_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire acts_pkg::t_cmd i_cmd,
    output acts_pkg::t_sts      o_sts,
    acts_chunk_if.sink          i_chunk,
    acts_result_if.source       o_result,
    acts_cfg_if.sink            i_cfg
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        bump = (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [31:0] low32(input logic [COUNT_BITS-1:0] c);
        logic [63:0] ext;
        ext   = 64'(c);
        low32 = ext[31:0];
    endfunction

    // configuration
    logic [62:0] r_epoch;
    logic [19:0] r_rate;

    // captured item
    logic        r_ok;
    logic [63:0] r_first;
    logic [31:0] r_count;
    logic [31:0] r_delay;
    logic        r_stv;
    logic [63:0] r_st;
    logic        r_disc;

    // persistent state
    logic                  r_anc_valid;
    logic [63:0]           r_anc_idx;
    logic [63:0]           r_anc_time;
    logic [63:0]           r_last_end;
    logic [COUNT_BITS-1:0] r_fail_cnt;
    logic [COUNT_BITS-1:0] r_re_cnt;
    logic [COUNT_BITS-1:0] r_disc_cnt;
    logic [COUNT_BITS-1:0] r_stamp_cnt;
    logic [62:0]           r_max_err;

    // per item work
    logic [3:0]  r_status;
    logic        r_re;
    logic [63:0] r_obs;
    logic [63:0] r_first_t;
    logic [63:0] r_end_t;
    logic [63:0] r_end_idx;
    logic [63:0] r_err;
    logic [62:0] r_pts;
    logic [62:0] r_dur;

    // result beat
    logic        r_out_valid;
    logic [3:0]  r_o_status;
    logic [62:0] r_o_pts;
    logic [62:0] r_o_dur;
    logic [63:0] r_o_pred;
    logic [63:0] r_o_obs;
    logic [63:0] r_o_err;
    logic        r_o_re;
    logic [31:0] r_o_fail;
    logic [31:0] r_o_recnt;
    logic [31:0] r_o_disc;
    logic [31:0] r_o_stamp;
    logic [62:0] r_o_max;

    // converter hookup
    logic        w_conv_start;
    logic [63:0] w_conv_frames;
    logic        w_conv_done;
    logic        w_conv_ok;
    logic [62:0] w_conv_ns;

    logic [3:0]  w_early;
    logic [63:0] w_obs;
    logic [64:0] w_anc_sum;
    logic        w_anc_ovf;
    logic [64:0] w_end_sum;
    logic        w_below2;
    logic [63:0] w_pts;
    logic [64:0] w_diff;
    logic [63:0] w_err;
    logic [63:0] w_abs;

    always_comb begin
        if (!r_ok) begin
            w_early = acts_pkg::STS_BAD_CHUNK;
        end else if (!r_stv) begin
            w_early = acts_pkg::STS_NO_TIME;
        end else if (r_st[63] || r_st == 64'd0) begin
            w_early = acts_pkg::STS_TIME_NONPOS;
        end else if (r_delay[31]) begin
            w_early = acts_pkg::STS_NEG_DELAY;
        end else begin
            w_early = acts_pkg::STS_OK;
        end

        case (i_cmd.op)
            acts_pkg::OP_P1: w_conv_frames = r_first - r_anc_idx;
            acts_pkg::OP_P2: w_conv_frames = r_end_idx - r_anc_idx;
            default:         w_conv_frames = 64'(r_delay) + 64'(r_count);
        endcase

        w_below2     = r_end_idx < r_anc_idx;
        w_conv_start = (i_cmd.op == acts_pkg::OP_EARLY && w_early == acts_pkg::STS_OK)
                    || (i_cmd.op == acts_pkg::OP_P1 && r_first >= r_anc_idx)
                    || (i_cmd.op == acts_pkg::OP_P2 && !w_below2);

        w_obs     = r_st - {1'b0, w_conv_ns};
        w_anc_sum = {r_anc_time[63], r_anc_time} + {2'b00, w_conv_ns};
        w_anc_ovf = (w_anc_sum[64:63] == 2'b01);
        w_end_sum = {1'b0, r_first} + {33'd0, r_count};

        w_pts  = r_first_t - {1'b0, r_epoch};
        w_diff = {r_obs[63], r_obs} - {r_first_t[63], r_first_t};
        if (w_diff[64:63] == 2'b01) begin
            w_err = acts_pkg::S64_MAX;
        end else if (w_diff[64:63] == 2'b10) begin
            w_err = acts_pkg::S64_MIN;
        end else begin
            w_err = w_diff[63:0];
        end
        if (w_err == acts_pkg::S64_MIN) begin
            w_abs = acts_pkg::S64_MAX;
        end else if (w_err[63]) begin
            w_abs = 64'd0 - w_err;
        end else begin
            w_abs = w_err;
        end
    end

    acts_conv u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_conv_start),
        .i_frames (w_conv_frames),
        .i_rate   (r_rate),
        .o_done   (w_conv_done),
        .o_ok     (w_conv_ok),
        .o_ns     (w_conv_ns)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch     <= acts_pkg::EPOCH_RST;
            r_rate      <= acts_pkg::RATE_RST;
            r_anc_valid <= 1'b0;
            r_anc_idx   <= 64'd0;
            r_anc_time  <= 64'd0;
            r_last_end  <= 64'd0;
            r_fail_cnt  <= '0;
            r_re_cnt    <= '0;
            r_disc_cnt  <= '0;
            r_stamp_cnt <= '0;
            r_max_err   <= 63'd0;
            r_status    <= acts_pkg::STS_OK;
            r_re        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == acts_pkg::CFG_EPOCH) begin
                    r_epoch <= i_cfg.data[62:0];
                end else if (i_cfg.index == acts_pkg::CFG_RATE) begin
                    r_rate <= i_cfg.data[19:0];
                end
            end

            // a load refills the register in the cycle the old beat leaves
            if (i_cmd.op == acts_pkg::OP_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (i_cmd.op)
                acts_pkg::OP_CAPTURE: begin
                    r_ok     <= i_chunk.chunk_ok;
                    r_first  <= i_chunk.first_frame_index;
                    r_count  <= i_chunk.num_frames;
                    r_delay  <= i_chunk.lag_frames;
                    r_stv    <= i_chunk.status_time_valid;
                    r_st     <= i_chunk.status_time_ns;
                    r_disc   <= i_chunk.discontinuity;
                    r_status <= acts_pkg::STS_OK;
                    r_re     <= 1'b0;
                end
                acts_pkg::OP_EARLY: begin
                    r_status <= w_early;
                    if (w_early == acts_pkg::STS_NO_TIME || w_early == acts_pkg::STS_TIME_NONPOS
                            || w_early == acts_pkg::STS_NEG_DELAY) begin
                        r_fail_cnt <= bump(r_fail_cnt);
                    end
                end
                acts_pkg::OP_OBS: begin
                    if (!w_conv_ok) begin
                        r_status <= acts_pkg::STS_TIME_OVF;
                    end else begin
                        r_obs <= w_obs;
                        if (!r_anc_valid || r_disc) begin
                            r_re        <= 1'b1;
                            r_anc_valid <= 1'b1;
                            r_anc_idx   <= r_first;
                            r_anc_time  <= w_obs;
                            r_re_cnt    <= bump(r_re_cnt);
                            if (r_disc) begin
                                r_disc_cnt <= bump(r_disc_cnt);
                            end
                        end
                    end
                end
                acts_pkg::OP_P1: begin
                    if (r_first < r_anc_idx) begin
                        r_status <= acts_pkg::STS_BEFORE_ANC;
                    end
                end
                acts_pkg::OP_P1_END: begin
                    if (!w_conv_ok || w_anc_ovf) begin
                        r_status <= acts_pkg::STS_TIME_OVF;
                    end else if (w_end_sum[64]) begin
                        r_status <= acts_pkg::STS_INDEX_OVF;
                    end else begin
                        r_first_t <= w_anc_sum[63:0];
                        r_end_idx <= w_end_sum[63:0];
                    end
                end
                acts_pkg::OP_P2: begin
                    if (w_below2) begin
                        r_status <= acts_pkg::STS_BEFORE_ANC;
                    end
                end
                acts_pkg::OP_P2_END: begin
                    if (!w_conv_ok || w_anc_ovf) begin
                        r_status <= acts_pkg::STS_TIME_OVF;
                    end else begin
                        r_end_t <= w_anc_sum[63:0];
                    end
                end
                acts_pkg::OP_FINAL: begin
                    if ($signed(r_first_t) < $signed({1'b0, r_epoch})) begin
                        r_status   <= acts_pkg::STS_PRE_EPOCH;
                        r_fail_cnt <= bump(r_fail_cnt);
                    end else if ($signed(r_end_t) <= $signed(r_first_t)) begin
                        r_status   <= acts_pkg::STS_NONPOS_DUR;
                        r_fail_cnt <= bump(r_fail_cnt);
                    end else if (r_stamp_cnt != '0 && $signed(w_pts) < $signed(r_last_end)) begin
                        r_status   <= acts_pkg::STS_OVERLAP;
                        r_fail_cnt <= bump(r_fail_cnt);
                    end else begin
                        r_err       <= w_err;
                        r_pts       <= w_pts[62:0];
                        r_dur       <= 63'(r_end_t - r_first_t);
                        r_last_end  <= r_end_t - {1'b0, r_epoch};
                        r_stamp_cnt <= bump(r_stamp_cnt);
                        if (w_abs > {1'b0, r_max_err}) begin
                            r_max_err <= w_abs[62:0];
                        end
                    end
                end
                acts_pkg::OP_LOAD: begin
                    r_o_status  <= r_status;
                    r_o_re      <= r_re;
                    r_o_fail    <= low32(r_fail_cnt);
                    r_o_recnt   <= low32(r_re_cnt);
                    r_o_disc    <= low32(r_disc_cnt);
                    r_o_stamp   <= low32(r_stamp_cnt);
                    r_o_max     <= r_max_err;
                    if (r_status == acts_pkg::STS_OK) begin
                        r_o_pts  <= r_pts;
                        r_o_dur  <= r_dur;
                        r_o_pred <= r_first_t;
                        r_o_obs  <= r_obs;
                        r_o_err  <= r_err;
                    end else begin
                        r_o_pts  <= 63'd0;
                        r_o_dur  <= 63'd0;
                        r_o_pred <= 64'd0;
                        r_o_obs  <= 64'd0;
                        r_o_err  <= 64'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign i_cfg.ready   = 1'b1;
    assign i_chunk.ready = i_cmd.in_ready;

    assign o_sts.in_valid  = i_chunk.valid;
    assign o_sts.fail      = (r_status != acts_pkg::STS_OK);
    assign o_sts.conv_done = w_conv_done;
    assign o_sts.out_busy  = r_out_valid & ~o_result.ready;

    assign o_result.valid               = r_out_valid;
    assign o_result.status              = r_o_status;
    assign o_result.pts_ns              = r_o_pts;
    assign o_result.span_ns             = r_o_dur;
    assign o_result.predicted_start_ns  = r_o_pred;
    assign o_result.observed_start_ns   = r_o_obs;
    assign o_result.start_error_ns      = r_o_err;
    assign o_result.reanchored          = r_o_re;
    assign o_result.failure_count       = r_o_fail;
    assign o_result.reanchor_count      = r_o_recnt;
    assign o_result.discontinuity_count = r_o_disc;
    assign o_result.stamped_count       = r_o_stamp;
    assign o_result.max_abs_error_ns    = r_o_max;

endmodule

`default_nettype wire
